@@ rtl/dpbe_pkg.sv @@
// Package: shared types and constants for the DCC packet bit encoder.
package dpbe_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ONE_HALF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HALF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 2'd3;

  localparam logic [7:0]  ONE_HALF_RESET  = 8'd58;
  localparam logic [7:0]  ZERO_HALF_RESET = 8'd100;
  localparam logic [15:0] PAUSE_RESET     = 16'd500;
  localparam logic [4:0]  PREAMBLE_RESET  = 5'd13;

  typedef struct packed {
    logic [7:0]  one_half_us;
    logic [7:0]  zero_half_us;
    logic [15:0] pause_half_us;
    logic [4:0]  preamble_bits;
  } cfg_regs_t;

  // One classified byte handed from the front end to the cell sequencer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] checksum;
    logic       preamble;
    logic       last_byte;
  } cmd_t;

endpackage

@@ rtl/dpbe_if.sv @@
// Interfaces: byte input, cell output and configuration write channels.
interface dpbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dpbe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] half_period_us;
  logic        bit_value;
  logic        is_pause;
  logic        last;
  modport source (output valid, output half_period_us, output bit_value,
                  output is_pause, output last, input ready);
  modport sink (input valid, input half_period_us, input bit_value,
                input is_pause, input last, output ready);
endinterface

interface dpbe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dpbe_pkg::CFG_IDX_W-1:0]  index;
  logic [dpbe_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/dcc_packet_bit_encoder.sv @@
// DCC packet bit encoder: takes packet bytes, gives DCC bit cells with their
// half-wave durations. Each byte accepted on in_bytes is classified by the
// front end (first byte of a packet or not, running XOR checksum) and placed
// in a short command queue; the cell sequencer expands each command into
// cells at one cell per clock while cells.ready is high. A byte that opens a
// packet gives preamble_bits ones and a zero start bit first; every byte
// gives its eight bits MSB first and a zero separator; a byte marked
// last_byte adds the eight checksum bits, a one stop bit and a pause cell.
// A byte therefore causes from 9 to 51 cells on the cells channel, each
// passing through the sequencer's output register; the queue accepts
// up to QUEUE_DEPTH further bytes while earlier ones are still being sent,
// and the sequencer moves straight from one command to the next. The flag
// last marks the final cell caused by each byte. Configuration registers
// (index 0 one_half_us, 1 zero_half_us, 2 pause_half_us, 3 preamble_bits)
// are written through cfg, which is always ready; write them only while the
// block is idle. There is no clearing pass after reset.
module dcc_packet_bit_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  dpbe_in_if.sink      in_bytes,
  dpbe_out_if.source   cells,
  dpbe_cfg_if.sink     cfg
);

  dpbe_pkg::cfg_regs_t cfg_regs;
  dpbe_pkg::cmd_t      push_cmd;
  dpbe_pkg::cmd_t      head;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_valid;

  // Configuration writes are always taken; excess data bits are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.one_half_us   <= dpbe_pkg::ONE_HALF_RESET;
      cfg_regs.zero_half_us  <= dpbe_pkg::ZERO_HALF_RESET;
      cfg_regs.pause_half_us <= dpbe_pkg::PAUSE_RESET;
      cfg_regs.preamble_bits <= dpbe_pkg::PREAMBLE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        dpbe_pkg::REG_ONE_HALF:  cfg_regs.one_half_us   <= cfg.data[7:0];
        dpbe_pkg::REG_ZERO_HALF: cfg_regs.zero_half_us  <= cfg.data[7:0];
        dpbe_pkg::REG_PAUSE:     cfg_regs.pause_half_us <= cfg.data;
        dpbe_pkg::REG_PREAMBLE:  cfg_regs.preamble_bits <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // Front end: classify each byte and track the open packet's checksum.
  dpbe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_bytes (in_bytes),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Decouple the byte side from the cell side.
  dpbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (head)
  );

  // Back end: emit cells, one transfer per clock when the sink keeps up.
  dpbe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .cells    (cells)
  );

endmodule

@@ rtl/dpbe_front.sv @@
// Front end: accept packet bytes, track packet state and checksum, queue commands.
module dpbe_front (
  input  logic              clk,
  input  logic              rst,
  dpbe_in_if.sink           in_bytes,
  input  logic              q_full,
  output logic              push,
  output dpbe_pkg::cmd_t    cmd
);

  logic       packet_open;
  logic [7:0] running_xor;
  logic [7:0] xor_next;

  assign in_bytes.ready = !q_full;
  assign push           = in_bytes.valid && !q_full;

  // A new packet starts its checksum from zero.
  assign xor_next = (packet_open ? running_xor : 8'd0) ^ in_bytes.data_byte;

  always_comb begin
    cmd.data_byte = in_bytes.data_byte;
    cmd.checksum  = xor_next;
    cmd.preamble  = !packet_open;
    cmd.last_byte = in_bytes.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      running_xor <= 8'd0;
    end else if (push) begin
      packet_open <= !in_bytes.last_byte;
      running_xor <= in_bytes.last_byte ? 8'd0 : xor_next;
    end
  end

endmodule

@@ rtl/dpbe_queue.sv @@
// Command queue: small FIFO between the front end and the cell sequencer.
module dpbe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dpbe_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output dpbe_pkg::cmd_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dpbe_pkg::cmd_t  store [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/dpbe_back.sv @@
// Cell sequencer: expand commands into bit cells, one per cycle unless stalled.
module dpbe_back (
  input  logic                clk,
  input  logic                rst,
  input  dpbe_pkg::cfg_regs_t cfg_regs,
  input  logic                q_valid,
  input  dpbe_pkg::cmd_t      head,
  output logic                pop,
  dpbe_out_if.source          cells
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRE   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_SEP   = 3'd4;
  localparam logic [2:0] ST_CSUM  = 3'd5;
  localparam logic [2:0] ST_STOP  = 3'd6;
  localparam logic [2:0] ST_PAUSE = 3'd7;

  logic [2:0]     state, state_next;
  logic [4:0]     cnt, cnt_next;
  dpbe_pkg::cmd_t cur;

  logic           advance;
  logic           cell_bit;
  logic           cell_pause;
  logic           cell_last;
  logic [15:0]    cell_half;
  logic           load;
  logic [2:0]     load_state;
  logic [4:0]     load_cnt;
  logic [2:0]     seq_state;
  logic [4:0]     seq_cnt;

  logic           out_valid;
  logic [15:0]    out_half;
  logic           out_bit;
  logic           out_pause;
  logic           out_last;

  assign advance = (state != ST_IDLE) && (!out_valid || cells.ready);

  // Entry point of a fresh command.
  always_comb begin
    if (head.preamble) begin
      if (cfg_regs.preamble_bits != 5'd0) begin
        load_state = ST_PRE;
        load_cnt   = cfg_regs.preamble_bits - 5'd1;
      end else begin
        load_state = ST_START;
        load_cnt   = 5'd0;
      end
    end else begin
      load_state = ST_DATA;
      load_cnt   = 5'd7;
    end
  end

  // Current cell and successor within the command.
  always_comb begin
    cell_bit   = 1'b0;
    cell_pause = 1'b0;
    cell_last  = 1'b0;
    seq_state  = state;
    seq_cnt    = cnt;
    unique case (state)
      ST_PRE: begin
        cell_bit = 1'b1;
        if (cnt == 5'd0) begin
          seq_state = ST_START;
        end else begin
          seq_cnt = cnt - 5'd1;
        end
      end
      ST_START: begin
        seq_state = ST_DATA;
        seq_cnt   = 5'd7;
      end
      ST_DATA: begin
        cell_bit = cur.data_byte[cnt[2:0]];
        if (cnt == 5'd0) begin
          seq_state = ST_SEP;
        end else begin
          seq_cnt = cnt - 5'd1;
        end
      end
      ST_SEP: begin
        if (cur.last_byte) begin
          seq_state = ST_CSUM;
          seq_cnt   = 5'd7;
        end else begin
          cell_last = 1'b1;
          seq_state = ST_IDLE;
        end
      end
      ST_CSUM: begin
        cell_bit = cur.checksum[cnt[2:0]];
        if (cnt == 5'd0) begin
          seq_state = ST_STOP;
        end else begin
          seq_cnt = cnt - 5'd1;
        end
      end
      ST_STOP: begin
        cell_bit  = 1'b1;
        seq_state = ST_PAUSE;
      end
      ST_PAUSE: begin
        cell_pause = 1'b1;
        cell_last  = 1'b1;
        seq_state  = ST_IDLE;
      end
      default: begin
        seq_state = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cell_pause) begin
      cell_half = cfg_regs.pause_half_us;
    end else if (cell_bit) begin
      cell_half = {8'd0, cfg_regs.one_half_us};
    end else begin
      cell_half = {8'd0, cfg_regs.zero_half_us};
    end
  end

  // Take the next command when idle or as the final cell of this one leaves.
  assign load = (state == ST_IDLE) || (advance && cell_last);
  assign pop  = load && q_valid;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    if (pop) begin
      state_next = load_state;
      cnt_next   = load_cnt;
    end else if (advance) begin
      state_next = seq_state;
      cnt_next   = seq_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 5'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (cells.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_half  <= cell_half;
      out_bit   <= cell_bit;
      out_pause <= cell_pause;
      out_last  <= cell_last;
    end
  end

  assign cells.valid          = out_valid;
  assign cells.half_period_us = out_half;
  assign cells.bit_value      = out_bit;
  assign cells.is_pause       = out_pause;
  assign cells.last           = out_last;

endmodule

@@ bench/dpbe_cell_checker.sv @@
// Checker for the DCC packet bit encoder: tracks the registers, predicts every cell, compares.
`timescale 1ns / 100ps
module dpbe_cell_checker (
  input  logic clk,
  input  logic rst,
  dpbe_in_if   in_bytes,
  dpbe_out_if  cells,
  dpbe_cfg_if  cfg,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [15:0] half_period_us;
    logic        bit_value;
    logic        is_pause;
    logic        last;
  } cell_t;

  cell_t               owed_cells[$];
  dpbe_pkg::cfg_regs_t regs;
  logic                pkt_open;
  logic [7:0]          pkt_xor;

  function automatic void owe_cell(logic [15:0] half, logic bv, logic pz);
    owed_cells.push_back('{half, bv, pz, 1'b0});
  endfunction

  function automatic void owe_bit(logic bv);
    owe_cell(bv ? {8'h00, regs.one_half_us} : {8'h00, regs.zero_half_us}, bv, 1'b0);
  endfunction

  function automatic void owe_octet(logic [7:0] v);
    for (int i = 7; i >= 0; i--) owe_bit(v[i]);
  endfunction

  // Expand one byte into the cells it causes, MSB first.
  function automatic void encode_byte(logic [7:0] b, logic lb);
    if (!pkt_open) begin
      for (int i = 0; i < int'(regs.preamble_bits); i++) owe_bit(1'b1);
      owe_bit(1'b0);
      pkt_open = 1'b1;
      pkt_xor  = 8'h00;
    end
    owe_octet(b);
    owe_bit(1'b0);
    pkt_xor ^= b;
    if (lb) begin
      owe_octet(pkt_xor);
      owe_bit(1'b1);
      owe_cell(regs.pause_half_us, 1'b0, 1'b1);
      pkt_open = 1'b0;
      pkt_xor  = 8'h00;
    end
    owed_cells[owed_cells.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    cell_t want;
    if (rst) begin
      regs = '{dpbe_pkg::ONE_HALF_RESET, dpbe_pkg::ZERO_HALF_RESET,
               dpbe_pkg::PAUSE_RESET, dpbe_pkg::PREAMBLE_RESET};
      pkt_open = 1'b0;
      pkt_xor  = 8'h00;
      owed_cells.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          dpbe_pkg::REG_ONE_HALF:  regs.one_half_us   = cfg.data[7:0];
          dpbe_pkg::REG_ZERO_HALF: regs.zero_half_us  = cfg.data[7:0];
          dpbe_pkg::REG_PAUSE:     regs.pause_half_us = cfg.data;
          dpbe_pkg::REG_PREAMBLE:  regs.preamble_bits = cfg.data[4:0];
          default: ;
        endcase
      end
      if (in_bytes.valid && in_bytes.ready)
        encode_byte(in_bytes.data_byte, in_bytes.last_byte);
      if (cells.valid && cells.ready) begin
        if (owed_cells.size() == 0) begin
          $error("unexpected cell: half_period_us %0d bit_value %0d is_pause %0d last %0d",
                 cells.half_period_us, cells.bit_value, cells.is_pause, cells.last);
          errors++;
        end else begin
          want = owed_cells.pop_front();
          check_field("half_period_us", want.half_period_us, cells.half_period_us);
          check_field("bit_value", want.bit_value, cells.bit_value);
          check_field("is_pause", want.is_pause, cells.is_pause);
          check_field("last", want.last, cells.last);
        end
      end
    end
    pending = owed_cells.size();
  end

endmodule

@@ bench/tb_dcc_packet_bit_encoder.sv @@
// Testbench top for the DCC packet bit encoder: stimulus, cell pacing and verdict.
`timescale 1ns / 100ps
module tb_dcc_packet_bit_encoder;

  // Worst case is far below this: up to 51 cells per byte plus hold-offs and gaps.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int          PHASE_ITEMS   = 56;
  localparam int          PHASES        = 7;

  // Ways the cell receiver paces its ready line.
  typedef enum logic [1:0] {PACE_FREE, PACE_COIN, PACE_THIRD, PACE_MOSTLY} pace_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          errors;
  int          pending;
  int unsigned cycles = 0;
  int          burst_left = 0;
  int          squeeze_req = 0;

  dpbe_in_if  in_bytes();
  dpbe_out_if cells();
  dpbe_cfg_if cfg();

  dcc_packet_bit_encoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_bytes (in_bytes),
    .cells    (cells),
    .cfg      (cfg)
  );

  dpbe_cell_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .in_bytes (in_bytes),
    .cells    (cells),
    .cfg      (cfg),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: abandon the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one byte and hold it until the transfer. The sender works in bursts;
  // between bursts drop valid for a random gap, sometimes none at all.
  task automatic push_byte(input logic [7:0] b, input logic lb);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_bytes.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_bytes.valid     <= 1'b1;
    in_bytes.data_byte <= b;
    in_bytes.last_byte <= lb;
    do @(posedge clk); while (!in_bytes.ready);
  endtask

  // Write one register and wait for its transfer.
  task automatic write_reg(input logic [dpbe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dpbe_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Full-width values: bits above each register's width must be dropped by the block.
  task automatic set_timing(input logic [15:0] one, input logic [15:0] zero,
                            input logic [15:0] pause, input logic [15:0] pre);
    write_reg(dpbe_pkg::REG_ONE_HALF, one);
    write_reg(dpbe_pkg::REG_ZERO_HALF, zero);
    write_reg(dpbe_pkg::REG_PAUSE, pause);
    write_reg(dpbe_pkg::REG_PREAMBLE, pre);
  endtask

  // Stop offering and wait until every predicted cell has come out.
  task automatic drain();
    @(negedge clk);
    in_bytes.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Well-formed packets of random length and content; mostly short, now and then long.
  task automatic send_packets(input int n_items);
    int         sent;
    int         len;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        push_byte(b, k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    in_bytes.valid     = 1'b0;
    in_bytes.data_byte = 8'h00;
    in_bytes.last_byte = 1'b0;
    cfg.valid          = 1'b0;
    cfg.index          = dpbe_pkg::REG_ONE_HALF;
    cfg.data           = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset durations: single-byte packets at both data extremes, then multi-byte ones.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'hF0, 1'b1);
    drain();

    // Zero durations everywhere and no preamble at all.
    set_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_byte(8'h3C, 1'b1);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h99, 1'b1);
    drain();

    // Junk in the upper bits, longest pause and a short preamble of eleven.
    set_timing(16'hFF2A, 16'h80D3, 16'hFFFF, 16'hFFEB);
    push_byte(8'h7E, 1'b1);
    push_byte(8'h81, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    drain();

    // Random part: each phase runs under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_timing(16'h00FF, 16'h00FF, 16'hFFFF, 16'h001F);
        1:       set_timing(16'h0001, 16'h0001, 16'h0001, 16'h000C);
        6:       set_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: set_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      // Ask the receiver for a long hold-off so that the queue fills and input stalls.
      if (p == 0 || p == 3) squeeze_req++;
      send_packets(PHASE_ITEMS);
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Cell receiver: stretches of different pacing, plus a long hold-off on request.
  initial begin : cell_pacing
    pace_t pace;
    int    span;
    int    served;
    served      = 0;
    cells.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (squeeze_req != served) begin
        served++;
        cells.ready <= 1'b0;
        repeat ($urandom_range(300, 450)) @(negedge clk);
      end
      pace = pace_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      for (int i = 0; i < span && squeeze_req == served; i++) begin
        case (pace)
          PACE_FREE:  cells.ready <= 1'b1;
          PACE_COIN:  cells.ready <= ($urandom_range(0, 1) == 1);
          PACE_THIRD: cells.ready <= (i % 3 == 0);
          default:    cells.ready <= ($urandom_range(0, 9) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

endmodule

@@ filelist.f @@
rtl/dpbe_pkg.sv
rtl/dpbe_if.sv
rtl/dpbe_front.sv
rtl/dpbe_queue.sv
rtl/dpbe_back.sv
rtl/dcc_packet_bit_encoder.sv
bench/dpbe_cell_checker.sv
bench/tb_dcc_packet_bit_encoder.sv
